// ===== src/psd_pkg.sv =====
// shared opcodes, field widths and control types for the positional shift deque
`default_nettype none
package psd_pkg;

  localparam int OP_W  = 3;
  localparam int POS_W = 6;
  localparam int VAL_W = 32;
  localparam int CNT_W = 6;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 72;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT     = 3'd0,
    OP_ERASE      = 3'd1,
    OP_PUSH_FRONT = 3'd2,
    OP_PUSH_BACK  = 3'd3,
    OP_POP_FRONT  = 3'd4,
    OP_POP_BACK   = 3'd5,
    OP_QUERY      = 3'd6
  } op_t;

  typedef struct packed {
    logic ins;
    logic era;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== src/positional_shift_deque_unit.sv =====
// top level: request decode, row of slot cells, count and result register
//
// channel  | dir | fields
// s_axis   | in  | tdata: op[2:0], position[8:3], value[40:9]
// m_axis   | out | tdata: ok[0], count[6:1], is_full[7], front_value[39:8],
//          |     |        back_value[71:40]
//
// for each item the cells shift on the accept edge, then the
// back value is selected from the cell row into the output register
// s_tready is low while a result is being formed; a stalled m_tready holds
// the result, one more request is taken and then the input waits
// rst clears the count and the handshake state; slot contents are not reset
`default_nettype none
module positional_shift_deque_unit #(
  parameter int DEPTH      = 32,
  parameter int DATA_WIDTH = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  input  wire logic [psd_pkg::IN_TDATA_W-1:0]     s_tdata,  // op, position, value
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  output logic      [psd_pkg::OUT_TDATA_W-1:0]    m_tdata   // ok, count, is_full, front, back
);
  import psd_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic [OP_W-1:0]       in_op;
  logic [POS_W-1:0]      in_pos;
  logic [VAL_W-1:0]      in_value;
  logic [DATA_WIDTH-1:0] word;

  logic [CW-1:0]         held;
  logic [CW-1:0]         held_next;
  logic                  pend;
  logic                  ok_r;

  logic                  accept;
  logic                  is_ins;
  logic                  is_era;
  logic                  ok_next;
  logic [PW-1:0]         held_w;
  logic [PW-1:0]         pos1;
  logic [PW-1:0]         pos0;
  logic                  ins_ok;
  logic                  era_ok;
  cell_ctl_t             ctl;

  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [DATA_WIDTH-1:0] back_word;
  logic [VAL_W-1:0]      front_out;
  logic [VAL_W-1:0]      back_out;

  assign in_op    = s_tdata[2:0];
  assign in_pos   = s_tdata[8:3];
  assign in_value = s_tdata[40:9];
  assign word     = DATA_WIDTH'(in_value);

  assign s_tready = !pend;
  assign accept   = s_tvalid && s_tready;
  assign held_w   = PW'(held);

  always_comb begin
    is_ins = 1'b0;
    is_era = 1'b0;
    pos1   = PW'(in_pos);
    case (op_t'(in_op))
      OP_INSERT: begin
        is_ins = 1'b1;
      end
      OP_ERASE: begin
        is_era = 1'b1;
      end
      OP_PUSH_FRONT: begin
        is_ins = 1'b1;
        pos1   = PW'(1);
      end
      OP_PUSH_BACK: begin
        is_ins = 1'b1;
        pos1   = held_w + PW'(1);
      end
      OP_POP_FRONT: begin
        is_era = 1'b1;
        pos1   = PW'(1);
      end
      OP_POP_BACK: begin
        is_era = 1'b1;
        pos1   = held_w;
      end
      default: begin
        is_ins = 1'b0;
        is_era = 1'b0;
      end
    endcase
  end

  assign pos0   = pos1 - PW'(1);
  assign ins_ok = is_ins && (pos1 != '0) && (pos1 <= held_w + PW'(1))
                  && (held_w < PW'(DEPTH));
  assign era_ok = is_era && (held != '0) && (pos1 != '0) && (pos1 <= held_w);
  assign ok_next = ins_ok || era_ok || (op_t'(in_op) == OP_QUERY);

  assign ctl = '{ins: accept && ins_ok, era: accept && era_ok};

  always_comb begin
    held_next = held;
    if (ctl.ins) begin
      held_next = held + CW'(1);
    end else if (ctl.era) begin
      held_next = held - CW'(1);
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_data;
    logic [DATA_WIDTH-1:0] right_data;
    if (g == 0) begin : g_first
      assign left_data = word;
    end else begin : g_mid_l
      assign left_data = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_data = cell_data[g];
    end else begin : g_mid_r
      assign right_data = cell_data[g+1];
    end
    psd_cell #(
      .INDEX      (g),
      .DATA_WIDTH (DATA_WIDTH),
      .PW         (PW)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .pos        (pos0),
      .word       (word),
      .left_data  (left_data),
      .right_data (right_data),
      .data       (cell_data[g])
    );
  end

  always_comb begin
    back_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (held == CW'(i + 1)) begin
        back_word = back_word | cell_data[i];
      end
    end
  end

  assign front_out = (held != '0) ? VAL_W'(64'(cell_data[0])) : '0;
  assign back_out  = VAL_W'(64'(back_word));

  always_ff @(posedge clk) begin
    if (rst) begin
      held     <= '0;
      pend     <= 1'b0;
      ok_r     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      held <= held_next;
      if (accept) begin
        pend <= 1'b1;
        ok_r <= ok_next;
      end
      if (pend && (!m_tvalid || m_tready)) begin
        pend     <= 1'b0;
        m_tvalid <= 1'b1;
        m_tdata  <= {back_out, front_out, (held == CW'(DEPTH)), CNT_W'(held), ok_r};
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/psd_cell.sv =====
// one slot of the list: holds a word and shifts from its left or right neighbor
`default_nettype none
module psd_cell #(
  parameter int INDEX      = 0,
  parameter int DATA_WIDTH = 32,
  parameter int PW         = 7
) (
  input  wire logic                   clk,
  input  wire psd_pkg::cell_ctl_t     ctl,
  input  wire logic [PW-1:0]          pos,
  input  wire logic [DATA_WIDTH-1:0]  word,
  input  wire logic [DATA_WIDTH-1:0]  left_data,
  input  wire logic [DATA_WIDTH-1:0]  right_data,
  output logic      [DATA_WIDTH-1:0]  data
);
  import psd_pkg::*;

  localparam logic [PW-1:0] IDX = PW'(INDEX);

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (IDX > pos) begin
        data <= left_data;
      end else if (IDX == pos) begin
        data <= word;
      end
    end else if (ctl.era && (IDX >= pos)) begin
      data <= right_data;
    end
  end

endmodule
`default_nettype wire
